[src/pbd_pkg.sv]
// shared widths, register indexes and types of the 2x2 pyramid downsampler
package pbd_pkg;

    localparam int PIX_W      = 8;
    localparam int SUM_W      = 9;
    localparam int QUAD_W     = 10;
    localparam int OUT_COL_W  = 10;
    localparam int OUT_ROW_W  = 11;
    localparam int FW_W       = 12;
    localparam int FH_W       = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [FW_W-1:0] FW_RESET = 12'd1920;
    localparam logic [FH_W-1:0] FH_RESET = 13'd1080;

    // one result in flight between the line store read and the output register
    typedef struct packed {
        logic [SUM_W-1:0]     sum_a;
        logic [SUM_W-1:0]     sum_b;
        logic [OUT_COL_W-1:0] col;
        logic [OUT_ROW_W-1:0] row;
        logic                 last;
    } res_t;

endpackage

[src/pyramid_box_downsample_2x2.sv]
// 2x2 box-filter decimation of two gray frames into one half-size pyramid level
//
// Input channel s_*: one pixel pair per transfer in raster order; s_frame_start
// restarts the position counters at that pixel. Result channel m_*: one result
// for each odd column of each odd row inside the even-sized area, carrying the
// floor of the 2x2 sums over four, its half-size position and a last flag.
// Configuration channel cfg_*: index 0 is frame_width, index 1 frame_height,
// always ready; sizes are clamped to [2, MAX_WIDTH] and [2, MAX_HEIGHT].
// A result passes the read stage, then the output register, after the transfer
// of the pixel that completes its 2x2 block. Throughput: one pixel pair per
// cycle while m_ready holds, set by the line store of column pair sums.
// Writes go on even rows, reads on odd rows, so one entry is never written
// and read by the same or neighboring transfers.
// Reset clears counters, held pixels, pipeline valids and restores the default
// sizes; the line store is not cleared and needs no sweep.
// When the receiver stalls, a read stage and the output register absorb two
// results, then s_ready drops until m_ready returns.
module pyramid_box_downsample_2x2
    import pbd_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PIX_W-1:0]      s_pixel_a,
    input  logic [PIX_W-1:0]      s_pixel_b,
    input  logic                  s_frame_start,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [PIX_W-1:0]      m_avg_a,
    output logic [PIX_W-1:0]      m_avg_b,
    output logic [OUT_COL_W-1:0]  m_out_col,
    output logic [OUT_ROW_W-1:0]  m_out_row,
    output logic                  m_frame_last,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int WW         = CW + 1;
    localparam int RH         = $clog2(MAX_HEIGHT);
    localparam int HW         = RH + 1;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int IW         = $clog2(LINE_DEPTH);

    logic [FW_W-1:0] frame_width_reg;
    logic [FH_W-1:0] frame_height_reg;
    logic [WW-1:0]   w_eff;
    logic [HW-1:0]   h_eff;

    logic [CW-1:0]    col_reg, col_next;
    logic [RH-1:0]    row_reg, row_next;
    logic [PIX_W-1:0] held_a_reg, held_b_reg;

    logic [CW-1:0]  col0, col_a;
    logic [RH-1:0]  row0, row_a;
    logic [HW-1:0]  row_t, row_n;
    logic [WW-1:0]  col_n;
    logic           wrap_pre;
    logic [SUM_W-1:0] sa, sb;
    logic [IW-1:0]  idx;
    logic           st_wr, st_out, last_flag;

    logic [2*SUM_W-1:0] line_mem [LINE_DEPTH];
    logic [2*SUM_W-1:0] rd_reg;

    logic s_acc, s1_adv;
    logic s1_valid_reg;
    res_t s1_reg;
    logic m_valid_reg;
    logic [QUAD_W-1:0] quad_a, quad_b;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FW_RESET;
            frame_height_reg <= FH_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FH_W-1:0];
            endcase
        end
    end

    always_comb begin
        if (frame_width_reg < FW_W'(2))
            w_eff = WW'(2);
        else if (32'(frame_width_reg) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(frame_width_reg);
        if (frame_height_reg < FH_W'(2))
            h_eff = HW'(2);
        else if (32'(frame_height_reg) > MAX_HEIGHT)
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(frame_height_reg);
    end

    // position of this pixel, then the position of the next one
    always_comb begin
        col0     = s_frame_start ? '0 : col_reg;
        row0     = s_frame_start ? '0 : row_reg;
        wrap_pre = {1'b0, col0} >= w_eff;
        col_a    = wrap_pre ? '0 : col0;
        row_t    = wrap_pre ? ({1'b0, row0} + HW'(1)) : {1'b0, row0};
        row_a    = (row_t >= h_eff) ? '0 : row_t[RH-1:0];

        col_n = {1'b0, col_a} + WW'(1);
        row_n = {1'b0, row_a} + HW'(1);
        if (col_n >= w_eff) begin
            col_next = '0;
            row_next = (row_n >= h_eff) ? '0 : row_n[RH-1:0];
        end else begin
            col_next = col_n[CW-1:0];
            row_next = row_a;
        end
    end

    assign sa        = SUM_W'(held_a_reg) + SUM_W'(s_pixel_a);
    assign sb        = SUM_W'(held_b_reg) + SUM_W'(s_pixel_b);
    assign idx       = IW'(col_a >> 1);
    assign st_wr     = s_acc && col_a[0] && !row_a[0];
    assign st_out    = col_a[0] && row_a[0];
    assign last_flag = (WW'(col_a >> 1) == ((w_eff >> 1) - WW'(1)))
                    && (HW'(row_a >> 1) == ((h_eff >> 1) - HW'(1)));

    assign s1_adv  = !m_valid_reg || m_ready;
    assign s_ready = !s1_valid_reg || s1_adv;
    assign s_acc   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            row_reg    <= '0;
            held_a_reg <= '0;
            held_b_reg <= '0;
        end else if (s_acc) begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (!col_a[0]) begin
                held_a_reg <= s_pixel_a;
                held_b_reg <= s_pixel_b;
            end
        end
    end

    // line store of pair sums: written on even rows, read on odd rows
    always_ff @(posedge aclk) begin
        if (st_wr)
            line_mem[idx] <= {sa, sb};
        if (s_acc && st_out)
            rd_reg <= line_mem[idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_acc) begin
            s1_valid_reg <= st_out;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc && st_out) begin
            s1_reg.sum_a <= sa;
            s1_reg.sum_b <= sb;
            s1_reg.col   <= OUT_COL_W'(col_a >> 1);
            s1_reg.row   <= OUT_ROW_W'(row_a >> 1);
            s1_reg.last  <= last_flag;
        end
    end

    assign quad_a = QUAD_W'(rd_reg[2*SUM_W-1:SUM_W]) + QUAD_W'(s1_reg.sum_a);
    assign quad_b = QUAD_W'(rd_reg[SUM_W-1:0]) + QUAD_W'(s1_reg.sum_b);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && s1_valid_reg) begin
            m_avg_a      <= quad_a[QUAD_W-1:2];
            m_avg_b      <= quad_b[QUAD_W-1:2];
            m_out_col    <= s1_reg.col;
            m_out_row    <= s1_reg.row;
            m_frame_last <= s1_reg.last;
        end
    end

    assign m_valid = m_valid_reg;

`ifndef SYNTH
    // an empty pipeline never blocks the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (!s1_valid_reg && !m_valid_reg) |-> s_ready)
        else $error("input blocked with empty pipeline");

    // a result waiting in the read stage is not overwritten by a new transfer
    a_s1_not_lost: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_reg)))
        else $error("read stage result lost");

    // the output register is only loaded from the read stage
    a_out_from_s1: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s1_valid_reg))
        else $error("output valid without a staged result");
`endif

endmodule
